>>> hw/rtl/ternary_terminated_code_decoder_macros.svh
// ============================================================================
// Ternary terminated code decoder - assertion macros
// Shared property wrappers, clocked on i_clk and quiet while in reset.
// ============================================================================
`ifndef TERNARY_TERMINATED_CODE_DECODER_MACROS_SVH
`define TERNARY_TERMINATED_CODE_DECODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define TCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcd assertion failed");

// Consequent checked in the cycle after the antecedent
`define TCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcd assertion failed");

`endif

>>> hw/rtl/tcd_pkg.sv
// ============================================================================
// Ternary terminated code decoder - package
// Symbol layout constants and the batch record passed to the output stage.
// ============================================================================
package tcd_pkg;

    localparam int BYTE_W        = 8;
    localparam int SYM_W         = 2;
    localparam int SYMS_PER_BYTE = 4;
    localparam int OUT_W         = 32;

    // Symbol code that closes a codeword
    localparam logic [SYM_W-1:0] SYM_END = 2'd3;

    // Results of one byte waiting for the output register
    typedef struct packed {
        logic [SYMS_PER_BYTE-1:0]            pend;
        logic [SYMS_PER_BYTE-1:0]            ovf;
        logic [SYMS_PER_BYTE-1:0][OUT_W-1:0] value;
    } t_batch;

endpackage

>>> hw/rtl/tcd_trit_step.sv
// ============================================================================
// Ternary terminated code decoder - symbol step
// Applies one 2-bit symbol to the accumulator: trit update with saturation,
// or codeword end (emit and clear).
// ============================================================================
module tcd_trit_step #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [VALUE_WIDTH-1:0]         i_acc,
    input  logic                           i_acc_ovf,
    input  logic [tcd_pkg::SYM_W-1:0]      i_sym,
    output logic [VALUE_WIDTH-1:0]         o_acc,
    output logic                           o_acc_ovf,
    output logic                           o_emit,
    output logic [tcd_pkg::OUT_W-1:0]      o_value,
    output logic                           o_value_ovf
);

    localparam int EXT_W = VALUE_WIDTH + 2;

    logic [EXT_W-1:0] wide;
    logic             sat;

    // acc*3 + trit + 1 never needs more than two extra bits
    assign wide = EXT_W'({i_acc, 1'b0}) + EXT_W'(i_acc) + EXT_W'(i_sym) + EXT_W'(1);
    assign sat  = |wide[EXT_W-1:VALUE_WIDTH];

    // Emitted result is the accumulator as it stands before this symbol
    assign o_emit      = (i_sym == tcd_pkg::SYM_END);
    assign o_value     = tcd_pkg::OUT_W'(i_acc);
    assign o_value_ovf = i_acc_ovf;

    always_comb begin
        if (o_emit) begin
            o_acc     = '0;
            o_acc_ovf = 1'b0;
        end else if (sat) begin
            o_acc     = '1;
            o_acc_ovf = 1'b1;
        end else begin
            o_acc     = wide[VALUE_WIDTH-1:0];
            o_acc_ovf = i_acc_ovf;
        end
    end

endmodule

>>> hw/rtl/tcd_unpack.sv
// ============================================================================
// Ternary terminated code decoder - byte unpack
// Holds the running accumulator, decodes all four symbols of an accepted
// byte in one pass and registers the codewords it completes as a batch.
// ============================================================================
module tcd_unpack #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [tcd_pkg::BYTE_W-1:0]           i_code_byte,
    input  logic                                 i_final_byte,
    input  logic [tcd_pkg::SYMS_PER_BYTE-1:0]    i_pop,
    output tcd_pkg::t_batch                      o_batch
);

    localparam int NS = tcd_pkg::SYMS_PER_BYTE;

    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_acc_ovf;
    tcd_pkg::t_batch        r_batch;

    logic [NS:0][VALUE_WIDTH-1:0]      acc_chain;
    logic [NS:0]                       ovf_chain;
    logic [NS-1:0]                     emit;
    logic [NS-1:0]                     emit_ovf;
    logic [NS-1:0][tcd_pkg::OUT_W-1:0] emit_value;
    logic                              accept;

    // Chain of symbol steps, low pair first
    assign acc_chain[0] = r_acc;
    assign ovf_chain[0] = r_acc_ovf;

    for (genvar g = 0; g < NS; g++) begin : g_step
        tcd_trit_step #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_step (
            .i_acc       (acc_chain[g]),
            .i_acc_ovf   (ovf_chain[g]),
            .i_sym       (i_code_byte[g*tcd_pkg::SYM_W +: tcd_pkg::SYM_W]),
            .o_acc       (acc_chain[g+1]),
            .o_acc_ovf   (ovf_chain[g+1]),
            .o_emit      (emit[g]),
            .o_value     (emit_value[g]),
            .o_value_ovf (emit_ovf[g])
        );
    end

    // Take a new byte once the batch drains this cycle
    assign o_in_stall = |(r_batch.pend & ~i_pop);
    assign accept     = i_in_valid && !o_in_stall;

    // Accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_acc_ovf <= 1'b0;
        end else if (accept) begin
            if (i_final_byte) begin
                r_acc     <= '0;
                r_acc_ovf <= 1'b0;
            end else begin
                r_acc     <= acc_chain[NS];
                r_acc_ovf <= ovf_chain[NS];
            end
        end
    end

    // Batch of pending results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch.pend <= '0;
        end else if (accept) begin
            r_batch.pend <= emit;
        end else begin
            r_batch.pend <= r_batch.pend & ~i_pop;
        end
        if (accept) begin
            r_batch.ovf   <= emit_ovf;
            r_batch.value <= emit_value;
        end
    end

    assign o_batch = r_batch;

endmodule

>>> hw/rtl/tcd_out.sv
// ============================================================================
// Ternary terminated code decoder - output register
// Moves pending results one per cycle unless the output stalls, in symbol
// order, into the result register and marks the last one of each byte.
// ============================================================================
module tcd_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tcd_pkg::t_batch                    i_batch,
    output logic [tcd_pkg::SYMS_PER_BYTE-1:0]  o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [tcd_pkg::OUT_W-1:0]          o_value,
    output logic                               o_overflow,
    output logic                               o_last
);

    localparam int NS = tcd_pkg::SYMS_PER_BYTE;

    logic                      r_valid;
    logic [tcd_pkg::OUT_W-1:0] r_value;
    logic                      r_ovf;
    logic                      r_last;

    logic                      out_free;
    logic                      load;
    logic [tcd_pkg::OUT_W-1:0] sel_value;
    logic                      sel_ovf;

    assign out_free = !r_valid || !i_out_stall;

    // Lowest pending slot goes first
    assign o_pop = out_free ? (i_batch.pend & (~i_batch.pend + NS'(1))) : '0;
    assign load  = |o_pop;

    always_comb begin
        sel_value = '0;
        sel_ovf   = 1'b0;
        for (int k = 0; k < NS; k++) begin
            sel_value = sel_value | (i_batch.value[k] & {tcd_pkg::OUT_W{o_pop[k]}});
            sel_ovf   = sel_ovf | (i_batch.ovf[k] & o_pop[k]);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (out_free) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= sel_value;
            r_ovf   <= sel_ovf;
            r_last  <= ~|(i_batch.pend & ~o_pop);
        end
    end

    assign o_out_valid = r_valid;
    assign o_value     = r_value;
    assign o_overflow  = r_ovf;
    assign o_last      = r_last;

endmodule

>>> hw/rtl/ternary_terminated_code_decoder.sv
// ============================================================================
// Ternary terminated code decoder - top level
// Byte-wide decoder for a stream of ternary codewords, each closed by an
// end symbol, producing one saturating integer per codeword.
// ============================================================================
// A byte is decoded in the cycle it is accepted; its results pass the batch
// register, then the result register. Unless the output stalls, bytes that
// close at most one codeword are taken one per cycle, and a byte closing
// several stalls the input as the result register sends one codeword per
// cycle. The next byte is accepted in the cycle its last result moves to
// that register. Bytes that close no codeword produce nothing. o_last marks
// the final result of each byte. A value that passes VALUE_WIDTH bits is
// held at all ones with o_overflow set; o_value carries its low 32 bits.
module ternary_terminated_code_decoder #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tcd_pkg::BYTE_W-1:0]    i_code_byte,
    input  logic                          i_final_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcd_pkg::OUT_W-1:0]     o_value,
    output logic                          o_overflow,
    output logic                          o_last
);

    tcd_pkg::t_batch                      batch;
    logic [tcd_pkg::SYMS_PER_BYTE-1:0]    pop;

    // Accumulator and per-byte decode
    tcd_unpack #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_unpack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_code_byte  (i_code_byte),
        .i_final_byte (i_final_byte),
        .i_pop        (pop),
        .o_batch      (batch)
    );

    // Result register
    tcd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_batch     (batch),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

endmodule

>>> hw/rtl/tcd_checker.sv
// ============================================================================
// Ternary terminated code decoder - port checker
// Watches the top-level ports for handshake and result ordering slips.
// ============================================================================
`include "ternary_terminated_code_decoder_macros.svh"

module tcd_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic [tcd_pkg::BYTE_W-1:0] i_code_byte,
    input logic                       i_final_byte,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [tcd_pkg::OUT_W-1:0]  o_value,
    input logic                       o_overflow,
    input logic                       o_last
);

    localparam logic [tcd_pkg::OUT_W-1:0] SAT_VALUE = tcd_pkg::OUT_W'({VALUE_WIDTH{1'b1}});

    // A stalled request stays put
    `TCD_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_code_byte) && $stable(i_final_byte))

    // A stalled result stays put
    `TCD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_value) && $stable(o_overflow) && $stable(o_last))

    // Saturated codewords read as all ones
    `TCD_ASSERT_SAME(a_sat_value, o_out_valid && o_overflow, o_value == SAT_VALUE)

    // Further results of the same byte follow without a gap
    `TCD_ASSERT_NEXT(a_byte_burst, o_out_valid && !o_last && !i_out_stall, o_out_valid)

endmodule

bind ternary_terminated_code_decoder tcd_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_tcd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_code_byte  (i_code_byte),
    .i_final_byte (i_final_byte),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_value      (o_value),
    .o_overflow   (o_overflow),
    .o_last       (o_last)
);

>>> bench/tb.sv
// ============================================================================
// Ternary terminated code decoder - testbench
// Sends code bytes in bursts with gaps and stalls the result side on its own
// pattern, with long hold-offs that back the decoder up. A scoreboard
// decodes each accepted request and compares every result with the oldest
// decoded codeword.
// ============================================================================

// One decoded codeword as it should leave the block
typedef struct packed {
    logic [tcd_pkg::OUT_W-1:0] value;
    logic                      overflow;
    logic                      last;
} t_codeword;

class codeword_board;
    t_codeword                 pending_words[$];
    logic [tcd_pkg::OUT_W-1:0] acc;
    logic                      acc_ovf;
    int unsigned               mismatches;

    function new();
        acc        = '0;
        acc_ovf    = 1'b0;
        mismatches = 0;
    endfunction

    // acc = acc*3 + digit, held at all ones once it no longer fits
    function void push_trit(logic [1:0] trit);
        logic [tcd_pkg::OUT_W+1:0] nxt;
        nxt = {2'b00, acc} * 34'd3 + 34'(trit) + 34'd1;
        if (nxt[tcd_pkg::OUT_W+1 -: 2] != 2'b00) begin
            acc     = '1;
            acc_ovf = 1'b1;
        end else begin
            acc = nxt[tcd_pkg::OUT_W-1:0];
        end
    endfunction

    // Decode one accepted request into the codewords it closes
    function void decode_request(logic [tcd_pkg::BYTE_W-1:0] code, logic fin);
        t_codeword   words[tcd_pkg::SYMS_PER_BYTE];
        int unsigned count;
        logic [1:0]  sym;
        count = 0;
        for (int i = 0; i < tcd_pkg::SYMS_PER_BYTE; i++) begin
            sym = code[2*i +: 2];
            if (sym == tcd_pkg::SYM_END) begin
                words[count].value    = acc;
                words[count].overflow = acc_ovf;
                words[count].last     = 1'b0;
                count++;
                acc     = '0;
                acc_ovf = 1'b0;
            end else begin
                push_trit(sym);
            end
        end
        if (count > 0) words[count-1].last = 1'b1;
        for (int i = 0; i < count; i++) pending_words.push_back(words[i]);
        // end of stream drops the open codeword
        if (fin) begin
            acc     = '0;
            acc_ovf = 1'b0;
        end
    endfunction

    function void check_word(logic [tcd_pkg::OUT_W-1:0] value, logic overflow,
                             logic last);
        t_codeword exp_word;
        if (pending_words.size() == 0) begin
            $error("unexpected result: value %0h overflow %0b last %0b",
                   value, overflow, last);
            mismatches++;
            return;
        end
        exp_word = pending_words.pop_front();
        if (value !== exp_word.value) begin
            $error("value: expected %0h, actual %0h", exp_word.value, value);
            mismatches++;
        end
        if (overflow !== exp_word.overflow) begin
            $error("overflow: expected %0b, actual %0b", exp_word.overflow, overflow);
            mismatches++;
        end
        if (last !== exp_word.last) begin
            $error("last: expected %0b, actual %0b", exp_word.last, last);
            mismatches++;
        end
    endfunction

    function int unsigned pending_count();
        return pending_words.size();
    endfunction
endclass

module tb;
    localparam int NUM_RANDOM = 350;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [tcd_pkg::BYTE_W-1:0]  i_code_byte;
    logic                        i_final_byte;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [tcd_pkg::OUT_W-1:0]   o_value;
    logic                        o_overflow;
    logic                        o_last;

    codeword_board board = new();
    int unsigned   burst_left;
    int unsigned   sent;

    ternary_terminated_code_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_code_byte  (i_code_byte),
        .i_final_byte (i_final_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value      (o_value),
        .o_overflow   (o_overflow),
        .o_last       (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Offer one request, hold it until taken, then close the burst if due
    task automatic send_byte(input logic [tcd_pkg::BYTE_W-1:0] code, input logic fin);
        int unsigned gap;
        i_in_valid   <= 1'b1;
        i_code_byte  <= code;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_in_stall);
        board.decode_request(code, fin);
        sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid  <= 1'b0;
                i_code_byte <= tcd_pkg::BYTE_W'($urandom_range(0, 255));
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Random byte, each symbol a terminator with the given percent chance
    function automatic logic [tcd_pkg::BYTE_W-1:0] symbol_byte(int unsigned end_pct);
        logic [tcd_pkg::BYTE_W-1:0] b;
        for (int i = 0; i < tcd_pkg::SYMS_PER_BYTE; i++) begin
            if ($urandom_range(0, 99) < end_pct) b[2*i +: 2] = tcd_pkg::SYM_END;
            else                                 b[2*i +: 2] = 2'($urandom_range(0, 2));
        end
        return b;
    endfunction

    // Result side: every accepted result goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_word(o_value, o_overflow, o_last);
    end

    // Receiver stall pattern, with one long hold-off early in the run
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned pct;
        do @(posedge i_clk); while (!i_rst_n);
        repeat (40) @(posedge i_clk) i_out_stall <= ($urandom_range(0, 99) < 30);
        i_out_stall <= 1'b1;
        repeat (250) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 9);
            span = $urandom_range(20, 80);
            if (mode < 3) begin
                i_out_stall <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else if (mode < 9) begin
                pct = $urandom_range(10, 70);
                repeat (span) @(posedge i_clk) i_out_stall <= ($urandom_range(0, 99) < pct);
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(60, 200)) @(posedge i_clk);
            end
        end
    end

    // Main stimulus
    initial begin
        int unsigned mode;
        int unsigned run;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_code_byte  <= '0;
        i_final_byte <= 1'b0;
        i_out_stall  <= 1'b0;
        burst_left   = $urandom_range(1, 24);
        sent         = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all-zero and all-one symbols, mixed terminators
        send_byte(8'h00, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hF7, 1'b0);
        // saturation: long codeword of the largest trit, then terminators
        repeat (6) send_byte(8'hAA, 1'b0);
        send_byte(8'h3F, 1'b0);
        // end of stream after a codeword closes inside the byte
        send_byte(8'h3A, 1'b1);
        send_byte(8'hFC, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'hE4, 1'b0);
        // saturated open codeword dropped by end of stream
        repeat (6) send_byte(8'hAA, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hC0, 1'b0);

        // Random part
        sent = 0;
        while (sent < NUM_RANDOM) begin
            mode = $urandom_range(0, 9);
            if (mode < 5) begin
                send_byte(symbol_byte(25), $urandom_range(0, 99) < 4);
            end else if (mode < 7) begin
                send_byte(tcd_pkg::BYTE_W'($urandom_range(0, 255)),
                          $urandom_range(0, 99) < 4);
            end else if (mode == 7) begin
                send_byte(symbol_byte(70), $urandom_range(0, 99) < 4);
            end else if (mode == 8) begin
                // long codeword, often reaching saturation
                run = $urandom_range(4, 9);
                repeat (run) send_byte(symbol_byte(0), 1'b0);
                send_byte(symbol_byte(40), $urandom_range(0, 99) < 10);
            end else begin
                send_byte(symbol_byte(25), 1'b1);
            end
        end
        i_in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (board.pending_count() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_count() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
